// ----- design/bba_pkg.sv -----
// Shared types and constants for the buddy block allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

   localparam int SPLIT_LEVELS = 10;
   localparam int LEAF_BYTES   = 4096;
   localparam int LEAF_SHIFT   = $clog2(LEAF_BYTES);
   localparam int REGION_BYTES = LEAF_BYTES << SPLIT_LEVELS;
   localparam int NODE_BITS    = SPLIT_LEVELS + 1;
   localparam int WORD_BITS    = 5;
   localparam int ROW_BITS     = NODE_BITS - WORD_BITS;
   localparam int ROWS         = 1 << ROW_BITS;
   localparam int WORD_WIDTH   = 1 << WORD_BITS;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_TOO_BIG   = 2'd1;
   localparam logic [1:0] STAT_NO_BLOCK  = 2'd2;
   localparam logic [1:0] STAT_NOT_ALLOC = 2'd3;

   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_FREE,
      OP_ERROR
   } op_type;

   typedef enum logic [3:0] {
      BS_IDLE,
      BS_SRCH_RD,
      BS_SRCH_CHK,
      BS_SUB_RD,
      BS_SUB_WR,
      BS_BIT_RD,
      BS_BIT_WR,
      BS_HEAD_RD,
      BS_HEAD_WR,
      BS_PAIR_RD,
      BS_PAIR_CHK,
      BS_DONE
   } bstate_type;

   typedef struct packed {
      logic        kind;
      logic [22:0] request_size;
      logic [3:0]  free_level;
      logic [9:0]  free_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  block_level;
      logic [9:0]  block_index;
      logic [21:0] byte_offset;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [1:0]  status;
      logic [3:0]  level;
      logic [9:0]  index;
   } cmd_type;

endpackage

`default_nettype wire

// ----- design/bba_front.sv -----
// Request classifier: picks the block level for an allocate and screens
// out bad requests. Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bba_front (
   input  bba_pkg::req_type req,
   output bba_pkg::cmd_type cmd
);
   import bba_pkg::*;

   logic [3:0] fit_level;
   logic [3:0] free_shift;

   always_comb begin
      fit_level = 4'd0;
      for (int l = 0; l < SPLIT_LEVELS; l++) begin
         if (req.request_size > (23'(LEAF_BYTES) << l)) begin
            fit_level = fit_level + 4'd1;
         end
      end
   end

   assign free_shift = 4'(SPLIT_LEVELS) - req.free_level;

   always_comb begin
      cmd.op     = OP_ERROR;
      cmd.status = STAT_OK;
      cmd.level  = 4'd0;
      cmd.index  = 10'd0;
      if (!req.kind) begin
         if (req.request_size > 23'(REGION_BYTES)) begin
            cmd.status = STAT_TOO_BIG;
         end else if (fit_level >= 4'(SPLIT_LEVELS)) begin
            // only the root would fit, and it is never free
            cmd.status = STAT_NO_BLOCK;
         end else begin
            cmd.op    = OP_ALLOC;
            cmd.level = fit_level;
         end
      end else begin
         if (req.free_level >= 4'(SPLIT_LEVELS)) begin
            cmd.status = STAT_NOT_ALLOC;
         end else if ((req.free_index >> free_shift) != 10'd0) begin
            cmd.status = STAT_NOT_ALLOC;
         end else begin
            cmd.op    = OP_FREE;
            cmd.level = req.free_level;
            cmd.index = req.free_index;
         end
      end
   end

endmodule

`default_nettype wire

// ----- design/bba_queue.sv -----
// Two-entry command queue between classifier and tree walker.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bba_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bba_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output bba_pkg::cmd_type head_cmd,
   output logic             not_empty
);
   import bba_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_cmd  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue push while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("queue pop while empty");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue count lost a transfer");

endmodule

`default_nettype wire

// ----- design/bba_back.sv -----
// Tree walker: searches, marks and clears the used and head bitmaps held
// as 32-bit rows, and builds the result. Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bba_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  bba_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bba_pkg::rsp_type rsp_data
);
   import bba_pkg::*;

   // bitmaps, one row per address; a row never written reads as zero
   logic [WORD_WIDTH-1:0] used_mem [ROWS];
   logic [WORD_WIDTH-1:0] head_mem [ROWS];
   logic [ROWS-1:0]       used_vld_ff;
   logic [ROWS-1:0]       head_vld_ff;
   logic [WORD_WIDTH-1:0] used_rd_ff, head_rd_ff;
   logic                  used_rvld_ff, head_rvld_ff;

   bstate_type state_ff, state_in;
   op_type     op_ff, op_in;
   logic [1:0] stat_ff, stat_in;
   logic [3:0] level_ff, level_in;
   logic [9:0] index_ff, index_in;
   logic [NODE_BITS-1:0] heap_ff, heap_in;
   logic [NODE_BITS-1:0] lo_ff, lo_in;
   logic [NODE_BITS-1:0] hi_ff, hi_in;
   logic [NODE_BITS-1:0] node_ff, node_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic [3:0] d_ff, d_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic [NODE_BITS-1:0]  base, last, q_base, found_node;
   logic [WORD_WIDTH-1:0] used_eff, head_eff, lvl_mask, free_bits, sub_mask;
   logic [WORD_WIDTH-1:0] bit_mask, head_bit;
   logic [WORD_BITS-1:0]  first_j;
   logic                  found, row_last, sub_end, depth_end, set_val, head_set, pair_free;
   logic [ROW_BITS-1:0]   sub_row, rd_row, wr_row;
   logic                  used_we, head_we;
   logic [WORD_WIDTH-1:0] used_wdata, head_wdata;

   assign base      = NODE_BITS'(1) << (4'(SPLIT_LEVELS) - level_ff);
   assign last      = NODE_BITS'((12'(base) << 1) - 12'd1);
   assign q_base    = NODE_BITS'(1) << (4'(SPLIT_LEVELS) - q_cmd.level);
   assign used_eff  = used_rvld_ff ? used_rd_ff : '0;
   assign head_eff  = head_rvld_ff ? head_rd_ff : '0;
   assign set_val   = (op_ff == OP_ALLOC);
   assign sub_row   = lo_ff[NODE_BITS-1:WORD_BITS];
   assign sub_end   = (hi_ff[NODE_BITS-1:WORD_BITS] == sub_row);
   assign depth_end = sub_end && (d_ff == level_ff);
   assign bit_mask  = WORD_WIDTH'(1) << node_ff[WORD_BITS-1:0];
   assign head_bit  = WORD_WIDTH'(1) << heap_ff[WORD_BITS-1:0];
   assign head_set  = head_eff[heap_ff[WORD_BITS-1:0]];
   assign pair_free = !used_eff[{node_ff[WORD_BITS-2:0], 1'b0}]
                   && !used_eff[{node_ff[WORD_BITS-2:0], 1'b1}];
   assign row_last  = ({row_ff, {WORD_BITS{1'b1}}} >= last);
   assign found_node = {row_ff, first_j};

   always_comb begin
      for (int j = 0; j < WORD_WIDTH; j++) begin
         lvl_mask[j] = ({row_ff, WORD_BITS'(j)} >= base) && ({row_ff, WORD_BITS'(j)} <= last);
         sub_mask[j] = (WORD_BITS'(j) >= lo_ff[WORD_BITS-1:0])
                    && (!sub_end || (WORD_BITS'(j) <= hi_ff[WORD_BITS-1:0]));
      end
      free_bits = lvl_mask & ~used_eff;
   end

   // lowest free position is the leftmost node
   always_comb begin
      found   = |free_bits;
      first_j = '0;
      for (int j = WORD_WIDTH - 1; j >= 0; j--) begin
         if (free_bits[j]) begin
            first_j = WORD_BITS'(j);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BS_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               case (q_cmd.op)
                  OP_ALLOC: state_in = BS_SRCH_RD;
                  OP_FREE:  state_in = BS_HEAD_RD;
                  default:  state_in = BS_DONE;
               endcase
            end
         end
         BS_SRCH_RD: state_in = BS_SRCH_CHK;
         BS_SRCH_CHK: begin
            if (found) begin
               state_in = BS_SUB_RD;
            end else if (row_last) begin
               state_in = BS_DONE;
            end else begin
               state_in = BS_SRCH_RD;
            end
         end
         BS_SUB_RD: state_in = BS_SUB_WR;
         BS_SUB_WR: begin
            if (!depth_end) begin
               state_in = BS_SUB_RD;
            end else if (set_val) begin
               state_in = BS_BIT_RD;
            end else if ((heap_ff >> 1) > NODE_BITS'(1)) begin
               state_in = BS_PAIR_RD;
            end else begin
               state_in = BS_DONE;
            end
         end
         BS_BIT_RD: state_in = BS_BIT_WR;
         BS_BIT_WR: begin
            if (set_val) begin
               state_in = ((node_ff >> 1) == '0) ? BS_HEAD_RD : BS_BIT_RD;
            end else begin
               state_in = ((node_ff >> 1) > NODE_BITS'(1)) ? BS_PAIR_RD : BS_DONE;
            end
         end
         BS_HEAD_RD: state_in = BS_HEAD_WR;
         BS_HEAD_WR: begin
            state_in = (!set_val && head_set) ? BS_SUB_RD : BS_DONE;
         end
         BS_PAIR_RD: state_in = BS_PAIR_CHK;
         BS_PAIR_CHK: state_in = pair_free ? BS_BIT_RD : BS_DONE;
         BS_DONE: state_in = BS_IDLE;
         default: state_in = BS_IDLE;
      endcase
   end

   // memory controls and queue pop
   always_comb begin
      q_pop      = 1'b0;
      used_we    = 1'b0;
      head_we    = 1'b0;
      wr_row     = sub_row;
      used_wdata = used_eff;
      head_wdata = head_eff;
      case (state_ff)
         BS_SUB_RD: rd_row = sub_row;
         BS_BIT_RD: rd_row = node_ff[NODE_BITS-1:WORD_BITS];
         BS_HEAD_RD: rd_row = heap_ff[NODE_BITS-1:WORD_BITS];
         BS_PAIR_RD: rd_row = node_ff[NODE_BITS-2:WORD_BITS-1];
         default: rd_row = row_ff;
      endcase
      case (state_ff)
         BS_IDLE: begin
            q_pop = q_valid && !rsp_valid_ff;
         end
         BS_SUB_WR: begin
            used_we    = 1'b1;
            used_wdata = set_val ? (used_eff | sub_mask) : (used_eff & ~sub_mask);
         end
         BS_BIT_WR: begin
            used_we    = 1'b1;
            wr_row     = node_ff[NODE_BITS-1:WORD_BITS];
            used_wdata = set_val ? (used_eff | bit_mask) : (used_eff & ~bit_mask);
         end
         BS_HEAD_WR: begin
            head_we    = set_val || head_set;
            wr_row     = heap_ff[NODE_BITS-1:WORD_BITS];
            head_wdata = set_val ? (head_eff | head_bit) : (head_eff & ~head_bit);
         end
         default: begin
         end
      endcase
   end

   // datapath registers
   always_comb begin
      op_in        = op_ff;
      stat_in      = stat_ff;
      level_in     = level_ff;
      index_in     = index_ff;
      heap_in      = heap_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      node_in      = node_ff;
      row_in       = row_ff;
      d_in         = d_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         BS_IDLE: begin
            if (q_pop) begin
               op_in    = q_cmd.op;
               stat_in  = q_cmd.status;
               level_in = q_cmd.level;
               index_in = q_cmd.index;
               row_in   = q_base[NODE_BITS-1:WORD_BITS];
               heap_in  = q_base + NODE_BITS'(q_cmd.index);
               lo_in    = q_base + NODE_BITS'(q_cmd.index);
               hi_in    = q_base + NODE_BITS'(q_cmd.index);
               d_in     = 4'd0;
            end
         end
         BS_SRCH_CHK: begin
            if (found) begin
               heap_in  = found_node;
               lo_in    = found_node;
               hi_in    = found_node;
               index_in = 10'(found_node - base);
               d_in     = 4'd0;
            end else if (row_last) begin
               stat_in = STAT_NO_BLOCK;
            end else begin
               row_in = row_ff + ROW_BITS'(1);
            end
         end
         BS_SUB_WR: begin
            if (depth_end) begin
               node_in = heap_ff >> 1;
            end else if (sub_end) begin
               // next depth starts at the leftmost descendant, not from the last row
               d_in  = d_ff + 4'd1;
               lo_in = heap_ff << (d_ff + 4'd1);
               hi_in = {hi_ff[NODE_BITS-2:0], 1'b1};
            end else begin
               lo_in = {sub_row + ROW_BITS'(1), {WORD_BITS{1'b0}}};
            end
         end
         BS_BIT_WR: begin
            node_in = node_ff >> 1;
         end
         BS_HEAD_WR: begin
            if (!set_val && !head_set) begin
               stat_in = STAT_NOT_ALLOC;
            end
            lo_in = heap_ff;
            hi_in = heap_ff;
            d_in  = 4'd0;
         end
         BS_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_data_in.status = stat_ff;
            if (stat_ff == STAT_OK) begin
               rsp_data_in.block_level = level_ff;
               rsp_data_in.block_index = index_ff;
               rsp_data_in.byte_offset =
                  22'(32'(index_ff) << (5'(LEAF_SHIFT) + 5'(level_ff)));
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[wr_row] <= used_wdata;
      end
      if (head_we) begin
         head_mem[wr_row] <= head_wdata;
      end
      used_rd_ff   <= used_mem[rd_row];
      head_rd_ff   <= head_mem[rd_row];
      used_rvld_ff <= used_vld_ff[rd_row];
      head_rvld_ff <= head_vld_ff[rd_row];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         rsp_valid_ff <= 1'b0;
         used_vld_ff  <= '0;
         head_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (used_we) begin
            used_vld_ff[wr_row] <= 1'b1;
         end
         if (head_we) begin
            head_vld_ff[wr_row] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      stat_ff     <= stat_in;
      level_ff    <= level_in;
      index_ff    <= index_in;
      heap_ff     <= heap_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      node_ff     <= node_in;
      row_ff      <= row_in;
      d_ff        <= d_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset) q_pop |-> !rsp_valid_ff)
      else $error("command taken while a result is pending");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BS_SUB_RD) |-> (lo_ff <= hi_ff))
      else $error("subtree span inverted");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != STAT_OK) |->
      (rsp_data_ff.block_level == 4'd0 && rsp_data_ff.block_index == 10'd0
       && rsp_data_ff.byte_offset == 22'd0))
      else $error("error result carries a block");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BS_BIT_WR && set_val) |-> (node_ff != '0))
      else $error("ancestor walk passed the root");

endmodule

`default_nettype wire

// ----- design/buddy_block_allocator_unit.sv -----
// Buddy block allocator: 1024 leaves of 4 KiB under ten split levels.
// A request is taken whenever the two-entry command queue has room; the tree
// walker then works one command at a time through its bitmap row port.
// Toward a result the walker reads each row searched, reads and rewrites each row marked or cleared,
// each ancestor set or cleared and the head row, and reads the row of each pair check.
// Reset clears the control state and the row valid bits; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module buddy_block_allocator_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bba_pkg::rsp_type rsp_data
);
   import bba_pkg::*;

   cmd_type front_cmd, head_cmd;
   logic    q_full, q_not_empty, q_pop;

   bba_front u_front (
      .req (req_data),
      .cmd (front_cmd)
   );

   bba_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && req_ready),
      .push_cmd  (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .head_cmd  (head_cmd),
      .not_empty (q_not_empty)
   );

   bba_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_cmd     (head_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign req_ready = !q_full;

endmodule

`default_nettype wire
